[rtl/hbcd_pkg.sv]
// ----------------------------------------------------------------------------
// hbcd_pkg
// Shared types, sizes and helpers of the hashed block cache directory.
// ----------------------------------------------------------------------------
`default_nettype none

package hbcd_pkg;

  localparam int SETS      = 13;
  localparam int WAYS      = 8;
  localparam int DEPTH     = SETS * WAYS;
  localparam int ADDR_W    = $clog2(DEPTH);

  localparam int ACT_W     = 2;
  localparam int DEV_W     = 8;
  localparam int BLK_W     = 32;
  localparam int SET_W     = 4;
  localparam int WAY_W     = 3;
  localparam int REF_W     = 8;

  localparam int BYTE_W    = 8;
  localparam int BLK_BYTES = BLK_W / BYTE_W;
  localparam int MOD_W     = SET_W + BYTE_W;

  localparam int IN_FIELDS_W  = DEV_W + BLK_W + SET_W + WAY_W;
  localparam int IN_W         = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = SET_W + WAY_W + 3 + DEV_W + BLK_W + 1;
  localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [REF_W-1:0] REFS_MAX = {REF_W{1'b1}};

  typedef enum logic [ACT_W-1:0] {
    ACT_GET     = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_PIN     = 2'd2,
    ACT_UNPIN   = 2'd3
  } action_e;

  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    logic             valid;
    logic [REF_W-1:0] refs;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             done;
    logic [SET_W-1:0] rem;
  } mod_stat_t;

  // (rem * 256 + b) mod SETS, rem < SETS; restoring compare-subtract
  function automatic logic [SET_W-1:0] mod_step(input logic [SET_W-1:0]  rem,
                                                 input logic [BYTE_W-1:0] b);
    logic [MOD_W-1:0] x;
    logic [MOD_W-1:0] m;
    x = {rem, b};
    for (int k = BYTE_W - 1; k >= 0; k--) begin
      m = MOD_W'(SETS) << k;
      if (x >= m) begin
        x = x - m;
      end
    end
    return x[SET_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/hbcd_ram.sv]
// ----------------------------------------------------------------------------
// hbcd_ram
// Generic RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hbcd_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/hbcd_mod.sv]
// ----------------------------------------------------------------------------
// hbcd_mod
// Block number modulo SETS, one byte per cycle, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module hbcd_mod
  import hbcd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [BLK_W-1:0] blk_i,
  output mod_stat_t             stat_o
);

  localparam int CNT_W = (BLK_BYTES > 1) ? $clog2(BLK_BYTES) : 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [BLK_W-1:0] sh_q, sh_d;
  logic [SET_W-1:0] rem_q, rem_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = blk_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = mod_step(rem_q, sh_q[BLK_W-1 -: BYTE_W]);
      sh_d  = sh_q << BYTE_W;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(BLK_BYTES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.rem  = rem_q;

endmodule

`default_nettype wire

[rtl/hashed_block_cache_directory.sv]
// ----------------------------------------------------------------------------
// hashed_block_cache_directory
// Set-associative directory of a disk block cache held in one entry RAM.
//
//   channel  dir  tdata / tuser                                 transfer
//   s_axis   in   {way,set,block,dev} / action                  tvalid & tready
//   m_axis   out  {err,old_block,old_dev,wb,read,hit,way,set}   tvalid & tready
//
// A get computes block mod SETS (one byte a cycle, then the done flag),
// scans the set way by way, updates one entry and hands off the result; the
// next input is taken after the hand-off. Release, pin and unpin read, then
// modify-write; an out-of-range buffer goes straight to the hand-off.
// Reset needs no clearing pass: per-entry written bits zero untouched entries.
// A stalled output register holds the next result in the hand-off state.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_block_cache_directory
  import hbcd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // dev[7:0], block_number[39:8], buffer_set[43:40], buffer_way[46:44]
  input  wire logic [IN_W-1:0]  s_axis_tdata_i,
  // action[1:0]
  input  wire logic [ACT_W-1:0] s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // set_index[3:0], way_index[6:4], hit[7], need_read[8], need_writeback[9],
  // old_dev[17:10], old_block[49:18], count_error[50]
  output logic [OUT_W-1:0]      m_axis_tdata_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MOD  = 6'b000010,
    ST_SCAN = 6'b000100,
    ST_UPD  = 6'b001000,
    ST_RMW  = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  typedef struct packed {
    logic             err;
    logic [BLK_W-1:0] oblk;
    logic [DEV_W-1:0] odev;
    logic             wb;
    logic             rd;
    logic             hit;
    logic [WAY_W-1:0] way;
    logic [SET_W-1:0] set;
  } result_t;

  localparam int RES_W = $bits(result_t);

  function automatic logic [ADDR_W-1:0] slot(input logic [SET_W-1:0] s,
                                             input logic [WAY_W-1:0] w);
    return ADDR_W'(int'(s) * WAYS + int'(w));
  endfunction

  state_e           state_q, state_d;
  action_e          act_q, act_d;
  logic [DEV_W-1:0] dev_q, dev_d;
  logic [BLK_W-1:0] blk_q, blk_d;
  logic [SET_W-1:0] set_q, set_d;
  logic [WAY_W-1:0] way_q, way_d;
  logic [WAY_W:0]   issue_q, issue_d;
  logic             rsp_vld_q, rsp_vld_d;
  logic [WAY_W-1:0] rsp_way_q, rsp_way_d;
  logic             hit_q, hit_d;
  logic [WAY_W-1:0] hway_q, hway_d;
  logic [REF_W-1:0] hrefs_q, hrefs_d;
  logic             hvalid_q, hvalid_d;
  logic             free_q, free_d;
  logic [WAY_W-1:0] fway_q, fway_d;
  entry_t           ev_q, ev_d;
  result_t          res_q, res_d;
  result_t          out_q;
  logic             out_vld_q, out_vld_d;
  logic             out_load;
  logic [DEPTH-1:0] written_q;
  logic             rd_written_q;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  entry_t             ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;

  mod_stat_t        mod_stat;
  logic             s_acc;
  action_e          in_act;
  logic [DEV_W-1:0] in_dev;
  logic [BLK_W-1:0] in_blk;
  logic [SET_W-1:0] in_set;
  logic [WAY_W-1:0] in_way;
  logic             in_range;

  logic             upd_err;
  logic             upd_wb;
  logic [WAY_W-1:0] upd_way;
  logic             cnt_err;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign in_act          = action_e'(s_axis_tuser_i);
  assign in_dev          = s_axis_tdata_i[DEV_W-1:0];
  assign in_blk          = s_axis_tdata_i[DEV_W +: BLK_W];
  assign in_set          = s_axis_tdata_i[DEV_W+BLK_W +: SET_W];
  assign in_way          = s_axis_tdata_i[DEV_W+BLK_W+SET_W +: WAY_W];
  assign in_range        = (int'(in_set) < SETS) && (int'(in_way) < WAYS);
  assign rd_entry        = rd_written_q ? entry_t'(ram_rdata) : '0;

  hbcd_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s_acc && (in_act == ACT_GET)),
    .blk_i   (in_blk),
    .stat_o  (mod_stat)
  );

  hbcd_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    dev_d     = dev_q;
    blk_d     = blk_q;
    set_d     = set_q;
    way_d     = way_q;
    issue_d   = issue_q;
    rsp_vld_d = 1'b0;
    rsp_way_d = issue_q[WAY_W-1:0];
    hit_d     = hit_q;
    hway_d    = hway_q;
    hrefs_d   = hrefs_q;
    hvalid_d  = hvalid_q;
    free_d    = free_q;
    fway_d    = fway_q;
    ev_d      = ev_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = slot(set_q, way_q);
    ram_wdata = rd_entry;
    ram_re    = 1'b0;
    ram_raddr = slot(in_set, in_way);
    upd_err   = 1'b0;
    upd_wb    = 1'b0;
    upd_way   = '0;
    cnt_err   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          act_d  = in_act;
          dev_d  = in_dev;
          blk_d  = in_blk;
          set_d  = in_set;
          way_d  = in_way;
          hit_d  = 1'b0;
          free_d = 1'b0;
          if (in_act == ACT_GET) begin
            state_d = ST_MOD;
          end else if (in_range) begin
            ram_re  = 1'b1;
            state_d = ST_RMW;
          end else begin
            res_d     = '0;
            res_d.set = in_set;
            res_d.way = in_way;
            res_d.err = 1'b1;
            state_d   = ST_DONE;
          end
        end
      end

      ST_MOD: begin
        if (mod_stat.done) begin
          set_d   = mod_stat.rem;
          issue_d = '0;
          state_d = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (int'(issue_q) < WAYS) begin
          ram_re    = 1'b1;
          ram_raddr = slot(set_q, issue_q[WAY_W-1:0]);
          issue_d   = issue_q + (WAY_W+1)'(1);
          rsp_vld_d = 1'b1;
        end
        if (rsp_vld_q) begin
          if (!hit_q && (rd_entry.dev == dev_q) && (rd_entry.blk == blk_q)) begin
            hit_d    = 1'b1;
            hway_d   = rsp_way_q;
            hrefs_d  = rd_entry.refs;
            hvalid_d = rd_entry.valid;
          end
          if (!free_q && (rd_entry.refs == '0)) begin
            free_d = 1'b1;
            fway_d = rsp_way_q;
          end
          if (rsp_way_q == '0) begin
            ev_d = rd_entry;
          end
          if (rsp_way_q == WAY_W'(WAYS - 1)) begin
            state_d = ST_UPD;
          end
        end
      end

      ST_UPD: begin
        ram_wdata.dev   = dev_q;
        ram_wdata.blk   = blk_q;
        ram_wdata.valid = 1'b1;
        if (hit_q) begin
          upd_way        = hway_q;
          upd_err        = (hrefs_q == REFS_MAX);
          ram_wdata.refs = upd_err ? hrefs_q : hrefs_q + REF_W'(1);
        end else begin
          upd_way        = free_q ? fway_q : '0;
          upd_wb         = !free_q && ev_q.valid;
          ram_wdata.refs = REF_W'(1);
        end
        ram_we     = 1'b1;
        ram_waddr  = slot(set_q, upd_way);
        way_d      = upd_way;
        res_d.set  = set_q;
        res_d.way  = upd_way;
        res_d.hit  = hit_q;
        res_d.rd   = hit_q ? !hvalid_q : 1'b1;
        res_d.wb   = upd_wb;
        res_d.odev = upd_wb ? ev_q.dev : '0;
        res_d.oblk = upd_wb ? ev_q.blk : '0;
        res_d.err  = upd_err;
        state_d    = ST_DONE;
      end

      ST_RMW: begin
        if (act_q == ACT_PIN) begin
          cnt_err        = (rd_entry.refs == REFS_MAX);
          ram_wdata.refs = rd_entry.refs + REF_W'(1);
        end else begin
          cnt_err        = (rd_entry.refs == '0);
          ram_wdata.refs = rd_entry.refs - REF_W'(1);
        end
        ram_we    = !cnt_err;
        res_d     = '0;
        res_d.set = set_q;
        res_d.way = way_q;
        res_d.err = cnt_err;
        state_d   = ST_DONE;
      end

      ST_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_load  = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready_i);
  assign out_vld_d = out_load || (out_vld_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_vld_q    <= 1'b0;
      rsp_vld_q    <= 1'b0;
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      rsp_vld_q <= rsp_vld_d;
      if (ram_we) begin
        written_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_written_q <= written_q[ram_raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    dev_q     <= dev_d;
    blk_q     <= blk_d;
    set_q     <= set_d;
    way_q     <= way_d;
    issue_q   <= issue_d;
    rsp_way_q <= rsp_way_d;
    hit_q     <= hit_d;
    hway_q    <= hway_d;
    hrefs_q   <= hrefs_d;
    hvalid_q  <= hvalid_d;
    free_q    <= free_d;
    fway_q    <= fway_d;
    ev_q      <= ev_d;
    res_q     <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OUT_W - RES_W){1'b0}}, out_q};

endmodule

`default_nettype wire

[rtl/hbcd_checker.sv]
// ----------------------------------------------------------------------------
// hbcd_checker
// Port-level checks of the directory, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hbcd_checker
  import hbcd_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid_i,
  input wire logic             s_axis_tready_o,
  input wire logic [IN_W-1:0]  s_axis_tdata_i,
  input wire logic [ACT_W-1:0] s_axis_tuser_i,
  input wire logic             m_axis_tvalid_o,
  input wire logic             m_axis_tready_i,
  input wire logic [OUT_W-1:0] m_axis_tdata_o
);

  logic       s_acc, m_acc;
  logic [1:0] pend_q;

  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(s_acc) - 2'(m_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o)
    else $error("input taken while an item is in work");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !$rose(m_axis_tvalid_o))
    else $error("result appeared in the cycle after input transfer");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_acc |-> (pend_q != 2'd0))
    else $error("result transfer without pending input");

endmodule

bind hashed_block_cache_directory hbcd_checker u_hbcd_checker (.*);

`default_nettype wire
